>>> rtl/core/fltw_pkg.sv
`timescale 1ns / 1ps

package fltw_pkg;

    localparam int TABLE_FRAMES      = 8;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int STORE_WORDS       = TABLE_FRAMES * ENTRIES_PER_TABLE;

    localparam int IDX_W   = 9;
    localparam int FRAME_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int ADDR_W  = FRAME_W + IDX_W;
    // wide enough for word_index and the store size
    localparam int WIDX_W  = ((ADDR_W > 12) ? ADDR_W : 12) + 1;

    localparam int PTE_P   = 0;
    localparam int PTE_PS  = 7;
    localparam int PFN_LO  = 12;
    localparam int PFN_HI  = 51;
    localparam int PFN_W   = PFN_HI - PFN_LO + 1;

    localparam logic [63:0] PTE_FRAME_MASK = 64'h000F_FFFF_FFFF_F000;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_PROTECT = 2'd2,
        CMD_UNMAP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_BEYOND    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2
    } pg_size_t;

    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } level_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_START = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // table index taken from the virtual address at a given level
    function automatic logic [IDX_W-1:0] va_index(input logic [47:0] va, input level_t lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/core/four_level_page_table_walker_core.sv
`timescale 1ns / 1ps

// Sequence: a write passes ST_START (store write) then ST_DONE; lookup, protect and
// unmap pass ST_START (root entry read), one ST_WALK per table level visited, ST_DONE.
// A new item is taken only in ST_IDLE, after the last result is loaded for output.
// Reset (rst_n low, async): clears control state, root frame to 0, then a
// clearing pass zeroes all 4096 table store words with s_tready low.
module four_level_page_table_walker_core
    import fltw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data,     // root_table_frame
    input  logic         s_tvalid,
    output logic         s_tready,
    // word_index[11:0], word_data[75:12], virt_addr[123:76], prot_flags[187:124]
    input  logic [191:0] s_tdata,
    input  logic [1:0]   s_tuser,      // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], entry[65:2], leaf_size[67:66]
    output logic [71:0]  m_tdata
);

    state_t           state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [2:0]       root_frame_reg;

    cmd_t             cmd_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic [63:0]      data_reg;
    logic [47:0]      va_reg;
    logic [63:0]      flags_reg;
    level_t           level_reg, level_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    status_t          status_reg, status_next;
    logic [63:0]      entry_reg, entry_next;
    pg_size_t         size_reg, size_next;

    logic             out_valid_reg;
    logic [71:0]      out_data_reg;

    logic [63:0]      mem [STORE_WORDS];
    logic [63:0]      rdata_reg;
    logic [ADDR_W-1:0] raddr;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [63:0]      mem_wdata;

    logic             in_xfer;
    logic             out_load;
    logic             root_beyond;
    logic             present, huge, pfn_beyond;
    logic [FRAME_W-1:0] next_frame;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign root_beyond = {5'd0, root_frame_reg} >= 8'(TABLE_FRAMES);
    assign present     = rdata_reg[PTE_P];
    assign huge        = rdata_reg[PTE_PS];
    assign pfn_beyond  = {1'b0, rdata_reg[PFN_HI:PFN_LO]} >= (PFN_W + 1)'(TABLE_FRAMES);
    assign next_frame  = rdata_reg[PFN_LO +: FRAME_W];

    always_comb
    begin
        state_next  = state_reg;
        level_next  = level_reg;
        addr_next   = addr_reg;
        status_next = status_reg;
        entry_next  = entry_reg;
        size_next   = size_reg;
        raddr       = addr_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = 64'd0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_W'(STORE_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next  = ST_START;
                    status_next = STAT_OK;
                    entry_next  = 64'd0;
                    size_next   = SIZE_4K;
                end
            end
            ST_START:
            begin
                state_next = ST_DONE;
                if (cmd_reg == CMD_WRITE)
                begin
                    if (widx_reg >= WIDX_W'(STORE_WORDS))
                        status_next = STAT_BEYOND;
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = widx_reg[ADDR_W-1:0];
                        mem_wdata = data_reg;
                    end
                end
                else if (root_beyond)
                    status_next = STAT_BEYOND;
                else
                begin
                    raddr      = {FRAME_W'(root_frame_reg), va_index(va_reg, LVL_PML4)};
                    addr_next  = raddr;
                    level_next = LVL_PML4;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                state_next = ST_DONE;
                if (!present)
                    status_next = STAT_NOT_FOUND;
                else if (level_reg == LVL_PT)
                begin
                    entry_next = rdata_reg;
                    if (cmd_reg == CMD_PROTECT)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = (rdata_reg & PTE_FRAME_MASK) | 64'd1 | flags_reg;
                    end
                    else if (cmd_reg == CMD_UNMAP)
                        mem_we = 1'b1;
                end
                else if (huge)
                begin
                    // huge leaf only counts for lookup below the top level
                    if (cmd_reg == CMD_LOOKUP && level_reg != LVL_PML4)
                    begin
                        entry_next = rdata_reg;
                        size_next  = (level_reg == LVL_PDPT) ? SIZE_1G : SIZE_2M;
                    end
                    else
                        status_next = STAT_NOT_FOUND;
                end
                else if (pfn_beyond)
                    status_next = STAT_BEYOND;
                else
                begin
                    level_next = level_t'(level_reg + 2'd1);
                    raddr      = {next_frame, va_index(va_reg, level_next)};
                    addr_next  = raddr;
                    state_next = ST_WALK;
                end
                // unmap of a missing page is not an error
                if (cmd_reg == CMD_UNMAP && status_next == STAT_NOT_FOUND)
                    status_next = STAT_OK;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            root_frame_reg <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (cfg_valid && cfg_ready)
                root_frame_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= cmd_t'(s_tuser);
            widx_reg  <= WIDX_W'(s_tdata[11:0]);
            data_reg  <= s_tdata[75:12];
            va_reg    <= s_tdata[123:76];
            flags_reg <= s_tdata[187:124];
        end
        level_reg  <= level_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
        size_reg   <= size_next;
        if (out_load)
            out_data_reg <= {4'd0, size_reg, entry_reg, status_reg};
    end

    // table store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[raddr];
    end

endmodule

>>> verif/tb_four_level_page_table_walker_core.sv
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_core;
    import fltw_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [11:0] word_index;
        logic [63:0] word_data;
        logic [47:0] virt_addr;
        logic [63:0] prot_flags;
    } walk_req_t;

    typedef struct {
        status_t     status;
        logic [63:0] entry;
        pg_size_t    leaf_size;
    } walk_rsp_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    // shadow of the table store and root register
    logic [63:0]  walk_mem [0:STORE_WORDS-1];
    logic [2:0]   root_frame_model = '0;
    walk_rsp_t    pending_rsp_q [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int rsp_checked = 0;
    int status_tally [0:2];
    int leaf_tally [0:2];
    int pause_count = 0;

    four_level_page_table_walker_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------
    // walk predictor
    // ---------------------------------------------------------------

    // strict: every level above the leaf must be a present, non-huge pointer
    function automatic void walk_to_entry(input logic [47:0] va, input bit strict_walk,
                                          output status_t st, output int unsigned leaf_addr,
                                          output pg_size_t sz);
        int unsigned fr;
        int unsigned slot;
        int          lvl;
        logic [63:0] e;
        bit          done;
        st = STAT_OK;
        sz = SIZE_4K;
        leaf_addr = 0;
        done = 1'b0;
        fr = 32'(root_frame_model);
        if (fr >= TABLE_FRAMES)
        begin
            st = STAT_BEYOND;
            done = 1'b1;
        end
        for (lvl = 0; lvl < 4 && !done; lvl++)
        begin
            slot = fr * ENTRIES_PER_TABLE + int'((va >> (39 - 9 * lvl)) & 48'h1FF);
            if (lvl == 3)
            begin
                leaf_addr = slot;
                done = 1'b1;
            end
            else
            begin
                e = walk_mem[slot];
                if (!e[PTE_P])
                begin
                    st = STAT_NOT_FOUND;
                    done = 1'b1;
                end
                else if (e[PTE_PS])
                begin
                    // huge at the top level is a conflict
                    if (!strict_walk && lvl != 0)
                    begin
                        leaf_addr = slot;
                        sz = (lvl == 1) ? SIZE_1G : SIZE_2M;
                    end
                    else
                        st = STAT_NOT_FOUND;
                    done = 1'b1;
                end
                else if (e[PFN_HI:PFN_LO] >= TABLE_FRAMES)
                begin
                    st = STAT_BEYOND;
                    done = 1'b1;
                end
                else
                    fr = int'(e[PFN_HI:PFN_LO]);
            end
        end
    endfunction

    function automatic walk_rsp_t predict_walk(input walk_req_t req);
        walk_rsp_t   rsp;
        status_t     st;
        pg_size_t    sz;
        int unsigned slot;
        logic [63:0] e;
        rsp.status = STAT_OK;
        rsp.entry = '0;
        rsp.leaf_size = SIZE_4K;
        case (req.cmd)
            CMD_WRITE:
            begin
                if (req.word_index < STORE_WORDS)
                    walk_mem[req.word_index] = req.word_data;
                else
                    rsp.status = STAT_BEYOND;
            end
            CMD_LOOKUP:
            begin
                walk_to_entry(req.virt_addr, 1'b0, st, slot, sz);
                if (st == STAT_OK && !walk_mem[slot][PTE_P])
                    st = STAT_NOT_FOUND;
                rsp.status = st;
                if (st == STAT_OK)
                begin
                    rsp.entry = walk_mem[slot];
                    rsp.leaf_size = sz;
                    leaf_tally[int'(sz)]++;
                end
            end
            CMD_PROTECT:
            begin
                walk_to_entry(req.virt_addr, 1'b1, st, slot, sz);
                if (st == STAT_OK)
                begin
                    e = walk_mem[slot];
                    if (e[PTE_P])
                    begin
                        walk_mem[slot] = (e & PTE_FRAME_MASK) | 64'h1 | req.prot_flags;
                        rsp.entry = e;
                    end
                    else
                        st = STAT_NOT_FOUND;
                end
                rsp.status = st;
            end
            default:
            begin
                // unmap of a missing page still reports ok
                walk_to_entry(req.virt_addr, 1'b1, st, slot, sz);
                if (st == STAT_NOT_FOUND)
                    rsp.status = STAT_OK;
                else
                    rsp.status = st;
                if (st == STAT_OK)
                begin
                    e = walk_mem[slot];
                    if (e[PTE_P])
                    begin
                        walk_mem[slot] = '0;
                        rsp.entry = e;
                    end
                end
            end
        endcase
        status_tally[int'(rsp.status)]++;
        return rsp;
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        walk_rsp_t exp_rsp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rsp_q.size() == 0)
                report_mismatch("unexpected result transfer", m_tdata[65:2], '0);
            else
            begin
                exp_rsp = pending_rsp_q.pop_front();
                rsp_checked++;
                if (m_tdata[1:0] !== exp_rsp.status)
                    report_mismatch("status", 64'(m_tdata[1:0]), 64'(exp_rsp.status));
                if (m_tdata[65:2] !== exp_rsp.entry)
                    report_mismatch("entry", m_tdata[65:2], exp_rsp.entry);
                if (m_tdata[67:66] !== exp_rsp.leaf_size)
                    report_mismatch("leaf_size", 64'(m_tdata[67:66]),
                                    64'(exp_rsp.leaf_size));
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic send_req(input walk_req_t req);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.cmd;
        s_tdata  <= {4'b0, req.prot_flags, req.virt_addr, req.word_data, req.word_index};
        do
            @(posedge clk);
        while (!s_tready);
        pending_rsp_q.push_back(predict_walk(req));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        pause_count++;
    endtask

    task automatic set_root(input logic [2:0] frame);
        drain_results();
        // let the last walk retire before touching the root
        repeat (10) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= frame;
        do
            @(posedge clk);
        while (!cfg_ready);
        root_frame_model = frame;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // item builders
    // ---------------------------------------------------------------

    function automatic walk_req_t mk_write(input logic [11:0] idx, input logic [63:0] data);
        walk_req_t req;
        req.cmd = CMD_WRITE;
        req.word_index = idx;
        req.word_data = data;
        req.virt_addr = 48'($urandom);
        req.prot_flags = {$urandom, $urandom};
        return req;
    endfunction

    function automatic walk_req_t mk_walk(input cmd_t cmd, input logic [47:0] va,
                                          input logic [63:0] flags);
        walk_req_t req;
        req.cmd = cmd;
        req.word_index = 12'($urandom);
        req.word_data = {$urandom, $urandom};
        req.virt_addr = va;
        req.prot_flags = flags;
        return req;
    endfunction

    function automatic logic [63:0] table_ptr(input int frame);
        return (64'(frame) << 12) | 64'h3;
    endfunction

    // table indexes cluster on a few slots so walks hit written words
    function automatic logic [8:0] pick_index();
        int r;
        r = $urandom_range(9);
        if (r < 3)
            return 9'd0;
        else if (r < 5)
            return 9'd1;
        else if (r < 7)
            return 9'd511;
        return 9'($urandom_range(511));
    endfunction

    function automatic logic [63:0] random_table_word();
        logic [63:0] e;
        int          kind;
        kind = $urandom_range(99);
        e = {$urandom, $urandom};
        if (kind < 45)
            e = table_ptr($urandom_range(TABLE_FRAMES - 1)) | (e & 64'hFFF0_0000_0000_0F7E);
        else if (kind < 60)
        begin
            e[PTE_P] = 1'b1;
            e[PTE_PS] = 1'b1;
        end
        else if (kind < 75)
            e[PTE_P] = 1'b1;
        else if (kind < 85)
        begin
            // pointer past the local store
            e[PTE_P] = 1'b1;
            e[PTE_PS] = 1'b0;
            if (e[PFN_HI:15] == '0)
                e[15] = 1'b1;
        end
        else
            e[PTE_P] = 1'b0;
        return e;
    endfunction

    function automatic walk_req_t random_req();
        logic [47:0] va;
        logic [63:0] flags;
        int          r;
        if ($urandom_range(9) == 0)
            va = 48'({$urandom, $urandom});
        else
            va = {pick_index(), pick_index(), pick_index(), pick_index(), 12'($urandom)};
        flags = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom_range(4095));
        r = $urandom_range(99);
        if (r < 30)
            return mk_write({3'($urandom_range(TABLE_FRAMES - 1)), pick_index()},
                            random_table_word());
        else if (r < 65)
            return mk_walk(CMD_LOOKUP, va, flags);
        else if (r < 85)
            return mk_walk(CMD_PROTECT, va, flags);
        return mk_walk(CMD_UNMAP, va, flags);
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_directed_walks();
        set_root(3'd0);
        send_req(mk_walk(CMD_LOOKUP, 48'h0, '0));
        send_req(mk_walk(CMD_PROTECT, 48'h0, '1));
        send_req(mk_walk(CMD_UNMAP, '1, '0));
        // full 4-level path for index 0 at every level: frames 0 -> 1 -> 2 -> 3
        send_req(mk_write(12'd0, table_ptr(1)));
        send_req(mk_write(12'd512, table_ptr(2)));
        send_req(mk_write(12'd1024, table_ptr(3)));
        send_req(mk_write(12'd1536, 64'h8000_0000_0001_2067));
        send_req(mk_walk(CMD_LOOKUP, 48'h0000_0000_0ABC, '0));
        send_req(mk_walk(CMD_PROTECT, 48'h0, '1));
        send_req(mk_walk(CMD_UNMAP, 48'h0, '0));
        send_req(mk_walk(CMD_UNMAP, 48'h0, '0));
        // 1 GiB leaf in the second level
        send_req(mk_write(12'd1023, 64'h0000_0000_C000_0083));
        send_req(mk_walk(CMD_LOOKUP, {9'd0, 9'd511, 18'd0, 12'hFFF}, '0));
        send_req(mk_walk(CMD_PROTECT, {9'd0, 9'd511, 30'd0}, '1));
        // 2 MiB leaf in the third level
        send_req(mk_write(12'd1535, 64'h0000_0000_1FE0_00E3));
        send_req(mk_walk(CMD_LOOKUP, {9'd0, 9'd0, 9'd511, 21'h1F_FFFF}, '0));
        // huge entry at the top level conflicts
        send_req(mk_write(12'd511, 64'h0000_0000_0000_0081));
        send_req(mk_walk(CMD_LOOKUP, '1, '0));
        // pointer to frame 9, past the store
        send_req(mk_write(12'd1, 64'h0000_0000_0000_9001));
        send_req(mk_walk(CMD_LOOKUP, {9'd1, 39'd0}, '0));
        send_req(mk_walk(CMD_UNMAP, {9'd1, 39'd0}, '0));
        send_req(mk_walk(CMD_PROTECT, {9'd1, 39'd0}, '0));
        send_req(mk_write(12'd4095, '1));
        send_req(mk_write(12'd4094, '0));
    endtask

    task automatic test_root_extremes();
        set_root(3'd7);
        // 7 -> 0 -> 1 -> 2, leaf is the frame 2 word pointing at frame 3
        send_req(mk_write(12'd3584, table_ptr(0)));
        send_req(mk_walk(CMD_LOOKUP, 48'h0, '0));
        send_req(mk_walk(CMD_PROTECT, 48'h0, '0));
        send_req(mk_walk(CMD_LOOKUP, 48'h0, '0));
    endtask

    task automatic test_random_walks(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int blk = 0; blk < 3; blk++)
        begin
            if (blk == 0)
                set_root(3'd0);
            else if (blk == 1)
                set_root(3'd7);
            else
                set_root(3'($urandom_range(TABLE_FRAMES - 1)));
            repeat (50) send_req(random_req());
        end
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            status_tally[i] = 0;
            leaf_tally[i] = 0;
        end
        for (int i = 0; i < STORE_WORDS; i++)
            walk_mem[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 31;
        sink_stall_pct = 81;
        test_directed_walks();
        test_root_extremes();
        test_random_walks(31, 81);
        test_random_walks(81, 31);
        test_random_walks(0, 0);

        drain_results();
        repeat (20) @(posedge clk);
        $display("Checked %0d results: %0d ok, %0d not found, %0d frame faults, %0d pauses",
                 rsp_checked, status_tally[0], status_tally[1], status_tally[2], pause_count);
        $display("Lookup hits: %0d on 4K pages, %0d on 2M pages, %0d on 1G pages",
                 leaf_tally[0], leaf_tally[1], leaf_tally[2]);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending_rsp_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
